// File: design/imh_pkg.sv
// imh_pkg: shared codes and fixed field widths of the indexed min-heap
// no dependencies
`default_nettype none
package imh_pkg;
    localparam int ID_W     = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_KEY_UP   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;
endpackage
`default_nettype wire

// File: design/imh_heap_ram.sv
// imh_heap_ram: heap slot store, one write port and two registered read ports
// depends on nothing
`default_nettype none
module imh_heap_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    ra_addr,
    output logic      [WIDTH-1:0] ra_data,
    input  wire logic [AW-1:0]    rb_addr,
    output logic      [WIDTH-1:0] rb_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end
endmodule
`default_nettype wire

// File: design/imh_pos_ram.sv
// imh_pos_ram: id to slot table, one write port and one registered read port
// depends on nothing
`default_nettype none
module imh_pos_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/indexed_min_heap_decrease_key.sv
// indexed_min_heap_decrease_key: top level, operation sequencer over the heap
// and position memories; uses imh_pkg, imh_heap_ram, imh_pos_ram
//
// channel | signals                                   | transfer when
// req     | req_valid req_ready mode item_id key      | req_valid & req_ready
// rsp     | rsp_valid rsp_ready status taken_id ...   | rsp_valid & rsp_ready
//
// one operation at a time; each sift level is a memory read (S_UP or S_DOWN),
// then a compare and write back (S_UPCMP or S_DNCMP)
// after reset a clearing pass zeroes the position table, with req_ready low
// a waiting result does not block the next request; a finished operation
// holds in its final state only while an older result is still untaken
`default_nettype none
module indexed_min_heap_decrease_key #(
    parameter int CAPACITY = 256,
    parameter int ID_COUNT = 256,
    parameter int KEY_BITS = 55
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [imh_pkg::MODE_W-1:0]        mode,
    input  wire logic [imh_pkg::ID_W-1:0]          item_id,
    input  wire logic [KEY_BITS-1:0]               key,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic      [imh_pkg::STATUS_W-1:0]      status,
    output logic      [imh_pkg::ID_W-1:0]          taken_id,
    output logic      [KEY_BITS-1:0]               taken_key,
    output logic      [imh_pkg::ID_W-1:0]          min_id,
    output logic      [KEY_BITS-1:0]               min_key,
    output logic      [$clog2(CAPACITY+1)-1:0]     entry_total,
    output logic                                   is_empty
);
    localparam int SW = $clog2(CAPACITY + 1);   // slot number, 0 means absent
    localparam int AW = $clog2(CAPACITY);       // heap address = slot - 1
    localparam int PW = $clog2(ID_COUNT);
    localparam int EW = imh_pkg::ID_W + KEY_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_DKEY  = 4'd3;
    localparam logic [3:0] S_LAST  = 4'd4;
    localparam logic [3:0] S_UP    = 4'd5;
    localparam logic [3:0] S_UPCMP = 4'd6;
    localparam logic [3:0] S_DOWN  = 4'd7;
    localparam logic [3:0] S_DNCMP = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]                     state_reg, state_next;
    logic [PW-1:0]                  clr_reg, clr_next;
    logic [imh_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [imh_pkg::ID_W-1:0]       e_id_reg, e_id_next;
    logic [KEY_BITS-1:0]            e_key_reg, e_key_next;
    logic [SW-1:0]                  s_reg, s_next;
    logic [SW-1:0]                  cnt_reg, cnt_next;
    logic [imh_pkg::ID_W-1:0]       root_id_reg, root_id_next;
    logic [KEY_BITS-1:0]            root_key_reg, root_key_next;
    logic [imh_pkg::STATUS_W-1:0]   code_reg, code_next;
    logic [imh_pkg::ID_W-1:0]       tk_id_reg, tk_id_next;
    logic [KEY_BITS-1:0]            tk_key_reg, tk_key_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic [imh_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [imh_pkg::ID_W-1:0]       taken_id_reg, taken_id_next;
    logic [KEY_BITS-1:0]            taken_key_reg, taken_key_next;
    logic [imh_pkg::ID_W-1:0]       min_id_reg, min_id_next;
    logic [KEY_BITS-1:0]            min_key_reg, min_key_next;
    logic [SW-1:0]                  total_reg, total_next;

    // memory ports
    logic          hw_en;
    logic [SW-1:0] hw_slot;
    logic [EW-1:0] hw_data;
    logic [AW-1:0] ha_addr, hb_addr;
    logic [EW-1:0] ha_data, hb_data;
    logic          pw_en;
    logic [PW-1:0] pw_addr;
    logic [SW-1:0] pw_data;
    logic [PW-1:0] pr_addr;
    logic [SW-1:0] pr_data;

    // sift helpers
    logic [SW:0]           l_slot;
    logic                  r_ok;
    logic [SW-1:0]         p_slot;
    logic [imh_pkg::ID_W-1:0] a_id, b_id;
    logic [KEY_BITS-1:0]   a_key, b_key;
    logic                  lt_le, lt_re, lt_rl, pick_l, pick_r;
    logic                  accept, id_bad;

    imh_heap_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_heap (
        .clk     (clk),
        .we      (hw_en),
        .waddr   (AW'(hw_slot - SW'(1))),
        .wdata   (hw_data),
        .ra_addr (ha_addr),
        .ra_data (ha_data),
        .rb_addr (hb_addr),
        .rb_data (hb_data)
    );

    imh_pos_ram #(.WIDTH(SW), .DEPTH(ID_COUNT), .AW(PW)) u_pos (
        .clk   (clk),
        .we    (pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .raddr (pr_addr),
        .rdata (pr_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign id_bad    = (32'(item_id) >= ID_COUNT);

    assign a_id  = ha_data[EW-1:KEY_BITS];
    assign a_key = ha_data[KEY_BITS-1:0];
    assign b_id  = hb_data[EW-1:KEY_BITS];
    assign b_key = hb_data[KEY_BITS-1:0];

    // children of the hole during sift-down, parent during sift-up
    assign l_slot = {s_reg, 1'b0};
    assign r_ok   = (l_slot < {1'b0, cnt_reg});
    assign p_slot = s_reg >> 1;
    assign lt_le  = (a_key < e_key_reg);
    assign lt_re  = (b_key < e_key_reg);
    assign lt_rl  = (b_key < a_key);
    assign pick_l = lt_le;
    assign pick_r = r_ok && (lt_le ? lt_rl : lt_re);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        e_id_next      = e_id_reg;
        e_key_next     = e_key_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        root_id_next   = root_id_reg;
        root_key_next  = root_key_reg;
        code_next      = code_reg;
        tk_id_next     = tk_id_reg;
        tk_key_next    = tk_key_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        taken_id_next  = taken_id_reg;
        taken_key_next = taken_key_reg;
        min_id_next    = min_id_reg;
        min_key_next   = min_key_reg;
        total_next     = total_reg;

        hw_en   = 1'b0;
        hw_slot = s_reg;
        hw_data = {e_id_reg, e_key_reg};
        ha_addr = AW'(s_reg - SW'(1));
        hb_addr = ha_addr;
        pw_en   = 1'b0;
        pw_addr = PW'(e_id_reg);
        pw_data = s_reg;
        pr_addr = PW'(item_id);

        unique case (state_reg)
            S_CLEAR:
            begin
                pw_en   = 1'b1;
                pw_addr = clr_reg;
                pw_data = '0;
                clr_next = clr_reg + PW'(1);
                if (clr_reg == PW'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode;
                    e_id_next   = item_id;
                    e_key_next  = key;
                    code_next   = imh_pkg::ST_OK;
                    tk_id_next  = '0;
                    tk_key_next = '0;
                    unique case (mode)
                        imh_pkg::MODE_INSERT, imh_pkg::MODE_DECREASE:
                        begin
                            if (id_bad)
                            begin
                                code_next  = imh_pkg::ST_ABSENT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_POS;
                            end
                        end
                        imh_pkg::MODE_DEL_MIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                code_next  = imh_pkg::ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                tk_id_next  = root_id_reg;
                                tk_key_next = root_key_reg;
                                pw_en       = 1'b1;
                                pw_addr     = PW'(root_id_reg);
                                pw_data     = '0;
                                cnt_next    = cnt_reg - SW'(1);
                                ha_addr     = AW'(cnt_reg - SW'(1));
                                state_next  = (cnt_reg == SW'(1)) ? S_DONE : S_LAST;
                            end
                        end
                        imh_pkg::MODE_UNUSED:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                if (mode_reg == imh_pkg::MODE_INSERT)
                begin
                    priority if (pr_data != '0)
                    begin
                        code_next  = imh_pkg::ST_DUPLICATE;
                        state_next = S_DONE;
                    end
                    else if (32'(cnt_reg) >= CAPACITY)
                    begin
                        code_next  = imh_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + SW'(1);
                        s_next     = cnt_reg + SW'(1);
                        state_next = S_UP;
                    end
                end
                else
                begin
                    if (pr_data == '0 || pr_data > cnt_reg)
                    begin
                        code_next  = imh_pkg::ST_ABSENT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        s_next     = pr_data;
                        ha_addr    = AW'(pr_data - SW'(1));
                        state_next = S_DKEY;
                    end
                end
            end
            S_DKEY:
            begin
                if (e_key_reg > a_key)
                begin
                    code_next  = imh_pkg::ST_KEY_UP;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP;
                end
            end
            S_LAST:
            begin
                // last entry becomes the moving entry, hole at the root
                e_id_next  = a_id;
                e_key_next = a_key;
                s_next     = SW'(1);
                state_next = S_DOWN;
            end
            S_UP:
            begin
                if (s_reg == SW'(1))
                begin
                    hw_en      = 1'b1;
                    pw_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ha_addr    = AW'(p_slot - SW'(1));
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (e_key_reg < a_key)
                begin
                    // parent drops into the hole
                    hw_en      = 1'b1;
                    hw_data    = ha_data;
                    pw_en      = 1'b1;
                    pw_addr    = PW'(a_id);
                    s_next     = p_slot;
                    state_next = S_UP;
                end
                else
                begin
                    hw_en      = 1'b1;
                    pw_en      = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DOWN:
            begin
                if (l_slot > {1'b0, cnt_reg})
                begin
                    hw_en      = 1'b1;
                    pw_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ha_addr    = AW'(l_slot - (SW+1)'(1));
                    hb_addr    = AW'(l_slot);
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
                priority if (pick_r)
                begin
                    hw_data    = hb_data;
                    pw_addr    = PW'(b_id);
                    s_next     = SW'(l_slot + (SW+1)'(1));
                    state_next = S_DOWN;
                end
                else if (pick_l)
                begin
                    hw_data    = ha_data;
                    pw_addr    = PW'(a_id);
                    s_next     = SW'(l_slot);
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = code_reg;
                    taken_id_next  = tk_id_reg;
                    taken_key_next = tk_key_reg;
                    min_id_next    = (cnt_reg == '0) ? '0 : root_id_reg;
                    min_key_next   = (cnt_reg == '0) ? '0 : root_key_reg;
                    total_next     = cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // root copy follows every write into the first slot
        if (hw_en && hw_slot == SW'(1))
        begin
            root_id_next  = hw_data[EW-1:KEY_BITS];
            root_key_next = hw_data[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        e_id_reg      <= e_id_next;
        e_key_reg     <= e_key_next;
        s_reg         <= s_next;
        root_id_reg   <= root_id_next;
        root_key_reg  <= root_key_next;
        code_reg      <= code_next;
        tk_id_reg     <= tk_id_next;
        tk_key_reg    <= tk_key_next;
        status_reg    <= status_next;
        taken_id_reg  <= taken_id_next;
        taken_key_reg <= taken_key_next;
        min_id_reg    <= min_id_next;
        min_key_reg   <= min_key_next;
        total_reg     <= total_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign taken_id    = taken_id_reg;
    assign taken_key   = taken_key_reg;
    assign min_id      = min_id_reg;
    assign min_key     = min_key_reg;
    assign entry_total = total_reg;
    assign is_empty    = (total_reg == '0);

`ifndef SYNTHESIS
    // count never passes the capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= CAPACITY)
        else $error("entry count above capacity");

    // heap writes stay inside the occupied slots
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        hw_en |-> (hw_slot != '0 && hw_slot <= cnt_reg))
        else $error("heap write outside occupied slots");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // failed operations report nothing removed
    a_err_no_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != imh_pkg::ST_OK) |-> (taken_id == '0 && taken_key == '0))
        else $error("error result carries a removed entry");
`endif
endmodule
`default_nettype wire

// File: sim/imh_checker.sv
// imh_checker: watches both channels of the indexed min-heap, keeps its own heap
// model, predicts each result and compares it field by field; uses imh_pkg
`timescale 1ns / 1ps
module imh_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  item_id,
    input  wire logic [54:0] key,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [2:0]  status,
    input  wire logic [7:0]  taken_id,
    input  wire logic [54:0] taken_key,
    input  wire logic [7:0]  min_id,
    input  wire logic [54:0] min_key,
    input  wire logic [8:0]  entry_total,
    input  wire logic        is_empty,
    output int               errors,
    output int               pending
);
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  taken_id;
        logic [54:0] taken_key;
        logic [7:0]  min_id;
        logic [54:0] min_key;
        logic [8:0]  total;
        logic        empty;
    } heap_result_t;

    logic [7:0]   slot_id  [1:256];
    logic [54:0]  slot_key [1:256];
    logic [8:0]   id_slot  [0:255];
    int           held;
    heap_result_t result_q[$];

    function automatic void swap_slots(int a, int b);
        logic [7:0]  ti;
        logic [54:0] tk;
        ti = slot_id[a];
        tk = slot_key[a];
        slot_id[a] = slot_id[b];
        slot_key[a] = slot_key[b];
        slot_id[b] = ti;
        slot_key[b] = tk;
        id_slot[slot_id[a]] = 9'(a);
        id_slot[slot_id[b]] = 9'(b);
    endfunction

    function automatic void lift(int s);
        while (s > 1) begin
            if (slot_key[s] < slot_key[s >> 1]) begin
                swap_slots(s, s >> 1);
                s = s >> 1;
            end
            else break;
        end
    endfunction

    function automatic void sink(int s);
        int best;
        forever begin
            best = s;
            if (2 * s <= held && slot_key[2 * s] < slot_key[best]) best = 2 * s;
            if (2 * s + 1 <= held && slot_key[2 * s + 1] < slot_key[best]) best = 2 * s + 1;
            if (best == s) break;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic heap_result_t apply_op(logic [1:0] op, logic [7:0] id, logic [54:0] k);
        heap_result_t r;
        int s;
        r = '0;
        r.status = imh_pkg::ST_OK;
        if (op == imh_pkg::MODE_INSERT) begin
            if (id_slot[id] != 0) r.status = imh_pkg::ST_DUPLICATE;
            else if (held >= 256) r.status = imh_pkg::ST_FULL;
            else begin
                held++;
                slot_id[held] = id;
                slot_key[held] = k;
                id_slot[id] = 9'(held);
                lift(held);
            end
        end
        else if (op == imh_pkg::MODE_DEL_MIN) begin
            if (held == 0) r.status = imh_pkg::ST_EMPTY;
            else begin
                r.taken_id = slot_id[1];
                r.taken_key = slot_key[1];
                swap_slots(1, held);
                id_slot[r.taken_id] = '0;
                held--;
                sink(1);
            end
        end
        else if (op == imh_pkg::MODE_DECREASE) begin
            s = id_slot[id];
            if (s == 0 || s > held) r.status = imh_pkg::ST_ABSENT;
            else if (k > slot_key[s]) r.status = imh_pkg::ST_KEY_UP;
            else begin
                slot_key[s] = k;
                lift(s);
            end
        end
        if (held != 0) begin
            r.min_id = slot_id[1];
            r.min_key = slot_key[1];
        end
        r.total = 9'(held);
        r.empty = (held == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        heap_result_t want;
        heap_result_t fresh;
        if (!rst_n) begin
            for (int i = 0; i < 256; i++) id_slot[i] = '0;
            held = 0;
            result_q.delete();
            errors = 0;
            pending <= 0;
        end
        else begin
            // the response transferred at this edge belongs to an older request
            if (rsp_valid && rsp_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end
                else begin
                    want = result_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("taken_id", want.taken_id, taken_id);
                    check_field("taken_key", want.taken_key, taken_key);
                    check_field("min_id", want.min_id, min_id);
                    check_field("min_key", want.min_key, min_key);
                    check_field("entry_total", want.total, entry_total);
                    check_field("is_empty", want.empty, is_empty);
                end
            end
            if (req_valid && req_ready) begin
                fresh = apply_op(mode, item_id, key);
                result_q = {result_q, fresh};
            end
            pending <= result_q.size();
        end
    end
endmodule

// File: sim/tb_indexed_min_heap_decrease_key.sv
// tb_indexed_min_heap_decrease_key: stimulus and verdict for the indexed min-heap
// uses imh_pkg, indexed_min_heap_decrease_key and imh_checker
`timescale 1ns / 1ps
module tb_indexed_min_heap_decrease_key;
    localparam logic [54:0] KEY_MAX = {55{1'b1}};
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  mode;
    logic [7:0]  item_id;
    logic [54:0] key;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  taken_id;
    logic [54:0] taken_key;
    logic [7:0]  min_id;
    logic [54:0] min_key;
    logic [8:0]  entry_total;
    logic        is_empty;
    int          errors;
    int          pending;

    // idling rates, in percent, for the current phase
    int          send_gap_pct;
    int          rsp_stall_pct;
    int          cycles = 0;
    // last key sent per id, so decreases mostly stay at or below the held key
    logic [54:0] last_key [0:255];

    indexed_min_heap_decrease_key dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .mode(mode), .item_id(item_id), .key(key),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .status(status), .taken_id(taken_id), .taken_key(taken_key),
        .min_id(min_id), .min_key(min_key),
        .entry_total(entry_total), .is_empty(is_empty)
    );

    imh_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .mode(mode), .item_id(item_id), .key(key),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .status(status), .taken_id(taken_id), .taken_key(taken_key),
        .min_id(min_id), .min_key(min_key),
        .entry_total(entry_total), .is_empty(is_empty),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls at random, once per cycle
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("indexed_min_heap_decrease_key: mismatch");
            $finish;
        end
    end

    // one request transfer, then a random gap; valid stays high when no gap follows
    task automatic send(logic [1:0] op, logic [7:0] id, logic [54:0] k);
        req_valid <= 1'b1;
        mode      <= op;
        item_id   <= id;
        key       <= k;
        if (op == imh_pkg::MODE_INSERT) last_key[id] = k;
        else if (op == imh_pkg::MODE_DECREASE && k <= last_key[id]) last_key[id] = k;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold off the sender until the checker has nothing outstanding
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [54:0] pick_key();
        case ($urandom_range(4))
            0: return 55'($urandom_range(15));
            1: return KEY_MAX;
            2: return KEY_MAX - 55'($urandom_range(7));
            default: return {$urandom, $urandom} & KEY_MAX;
        endcase
    endfunction

    task automatic random_item();
        logic [7:0]  id;
        logic [54:0] k;
        int          roll;
        id = ($urandom_range(9) < 8) ? 8'($urandom_range(47)) : 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 42) send(imh_pkg::MODE_INSERT, id, pick_key());
        else if (roll < 67)
            send(imh_pkg::MODE_DEL_MIN, 8'($urandom), {$urandom, $urandom} & KEY_MAX);
        else if (roll < 95) begin
            // mostly legal decreases, now and then a raise or an equal key
            if ($urandom_range(4) == 0) k = pick_key();
            else if (last_key[id] < 55'd4) k = last_key[id];
            else k = last_key[id] - 55'($urandom_range(3))
                     - ($urandom_range(1) ? 55'($urandom) : 55'd0);
            send(imh_pkg::MODE_DECREASE, id, k);
        end
        else send(imh_pkg::MODE_UNUSED, id, pick_key());
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        mode = imh_pkg::MODE_INSERT;
        item_id = '0;
        key = '0;
        send_gap_pct = 0;
        rsp_stall_pct = 0;
        for (int i = 0; i < 256; i++) last_key[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: key extremes, ties, every status but full, unused mode
        send(imh_pkg::MODE_DEL_MIN, 8'd0, '0);
        send(imh_pkg::MODE_DECREASE, 8'd9, '0);
        send(imh_pkg::MODE_INSERT, 8'd0, KEY_MAX);
        send(imh_pkg::MODE_INSERT, 8'd255, '0);
        send(imh_pkg::MODE_INSERT, 8'd170, '0);
        send(imh_pkg::MODE_INSERT, 8'd85, 55'd5);
        send(imh_pkg::MODE_INSERT, 8'd255, 55'd1);
        send(imh_pkg::MODE_DECREASE, 8'd0, KEY_MAX);
        send(imh_pkg::MODE_DECREASE, 8'd85, 55'd100);
        send(imh_pkg::MODE_DECREASE, 8'd7, '0);
        send(imh_pkg::MODE_DECREASE, 8'd0, 55'd3);
        send(imh_pkg::MODE_UNUSED, 8'd255, KEY_MAX);
        send(imh_pkg::MODE_DEL_MIN, 8'd0, '0);
        send(imh_pkg::MODE_DECREASE, 8'd85, '0);
        repeat (5) send(imh_pkg::MODE_DEL_MIN, 8'd0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_gap_pct = 45; rsp_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  rsp_stall_pct = 45; end
                default: begin send_gap_pct = 32; rsp_stall_pct = 32; end
            endcase
            if (ph == 1) begin
                // every id in, heap full, then drained past empty
                for (int i = 0; i < 256; i++) send(imh_pkg::MODE_INSERT, 8'(i), pick_key());
                send(imh_pkg::MODE_INSERT, 8'($urandom), pick_key());
                repeat (258) send(imh_pkg::MODE_DEL_MIN, 8'($urandom), '0);
            end
            repeat (280) random_item();
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("indexed_min_heap_decrease_key: match");
        else
            $display("indexed_min_heap_decrease_key: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
design/imh_pkg.sv
design/imh_heap_ram.sv
design/imh_pos_ram.sv
design/indexed_min_heap_decrease_key.sv
sim/imh_checker.sv
sim/tb_indexed_min_heap_decrease_key.sv
